### rtl/best_fit_allocator_with_compaction_assert.svh
// Assertion macros for the best-fit allocator.
// Used by rtl/best_fit_allocator_with_compaction.sv; no other dependencies.
`ifndef BEST_FIT_ALLOCATOR_WITH_COMPACTION_ASSERT_SVH
`define BEST_FIT_ALLOCATOR_WITH_COMPACTION_ASSERT_SVH

// Condition checked every cycle outside reset.
`define BFA_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/bfa_pkg.sv
// Shared constants and types for the best-fit allocator.
// No dependencies.
package bfa_pkg;
  localparam int MemWords  = 1024;
  localparam int MaxBlocks = 64;
  localparam int WordBits  = 32;
  localparam int HoleDepth = MaxBlocks + 1;
  localparam int AW = $clog2(MemWords);      // word address
  localparam int LW = AW + 1;                // length / count of words
  localparam int UW = $clog2(MaxBlocks);     // used table index
  localparam int HW = $clog2(HoleDepth);     // hole list index
  localparam int CW = HW + 1;                // counts up to HoleDepth

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_DATA  = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_TBL_FULL  = 3'd3,
    ST_BAD_ITEM  = 3'd4
  } status_t;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [LW-1:0] len;
    logic [15:0]   handle;
  } used_ent_t;

  typedef struct packed {
    logic [LW-1:0] start;
    logic [LW-1:0] len;
  } hole_ent_t;
endpackage

### rtl/best_fit_allocator_with_compaction.sv
// Top level of the best-fit word allocator with coalescing and compaction.
// Depends on bfa_pkg and best_fit_allocator_with_compaction_assert.svh.
//
// Usage:
//  in_*  : request items. tuser = req_type (0 alloc, 1 free, 2 data word).
//          tdata = {data_word, handle_in, alloc_size}, alloc_size at bit 0.
//  out_* : one result item per request, tdata = {free_words, compacted,
//          start_addr, handle_out, status}, status at bit 0.
// Each item is taken, worked by a small sequencer that touches one table
// entry or one memory word per step, then its result is held in an output
// register. in_tready is low from accept until the result is taken.
// Tables are read through registered ports, so a scan or shift step has an
// address state, then a data state. An alloc with an exact fit, and a free that
// merges on both sides or inserts a hole, shift entries of the hole list.
// Compaction rewrites each block's entry and moves each word with a memory
// read, then a write. out_tvalid is registered and rises once the work ends;
// in_tready returns the cycle after the result is taken, so a new item is not
// taken before the result of the last one has been taken.
// Reset: tables empty, one hole covering memory, all MemWords words free.
// No clearing pass is needed: word contents never reach a result.
// When the receiver stalls, out_tvalid and the payload hold and no new
// item is taken.
module best_fit_allocator_with_compaction (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // req_type
  input  logic [63:0] in_tdata,   // alloc_size[10:0], handle_in[26:11], data_word[58:27]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[2:0], handle_out[18:3], start_addr[28:19],
                                  // compacted[29], free_words[40:30]
);
  import bfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_DATA, S_AS_RD, S_AS_EV, S_AP_RD, S_AP_EV, S_ASH_RD, S_ASH_WR, S_AFIN,
    S_CS_RD, S_CS_EV, S_CRD, S_CWR, S_CDONE,
    S_FF_RD, S_FF_EV, S_FS_RD, S_FS_WR, S_HS_RD, S_HS_EV, S_HMERGE,
    S_HD_RD, S_HD_WR, S_HI_RD, S_HI_WR, S_DONE, S_OUT
  } state_t;

  state_t state_r;
  used_ent_t used_mem [MaxBlocks];
  hole_ent_t hole_mem [HoleDepth];
  logic [WordBits-1:0] word_mem [MemWords];
  logic [WordBits-1:0] rd_r;
  used_ent_t u_rd_r;
  hole_ent_t h_rd_r;

  logic [UW:0]   used_cnt_r;
  logic [CW-1:0] hole_cnt_r;
  logic [LW-1:0] free_r;
  logic [15:0]   next_h_r;
  logic [LW-1:0] fill_addr_r, fill_left_r;

  logic [1:0]    req_r;
  logic [LW-1:0] size_r;
  logic [15:0]   hin_r;
  logic [WordBits-1:0] dw_r;

  logic [CW-1:0] i_r;        // hole index
  logic [UW:0]   u_r;        // used index
  logic [CW-1:0] best_r;
  logic          best_v_r;
  logic [LW-1:0] best_len_r;
  logic [AW-1:0] addr_r;
  logic [LW-1:0] dst_r, w_r, src_r;
  logic [LW-1:0] fl_r, fsz_r;
  logic          prev_r, next_r;
  hole_ent_t     hp_r, he_r;   // hole below / above the freed block

  logic [2:0]    st_r;
  logic [15:0]   ho_r;
  logic [AW-1:0] ao_r;
  logic          co_r;
  logic          outv_r;

  logic [HW-1:0] ih, ihm1, h_ra;
  logic [UW-1:0] uu, u_ra;
  logic [UW:0] ucnt_m1;
  logic [LW-1:0] dw_addr, sw_addr;

  assign ih   = i_r[HW-1:0];
  assign ihm1 = HW'(i_r - 1'b1);
  assign uu   = u_r[UW-1:0];
  assign ucnt_m1 = used_cnt_r - 1'b1;
  assign dw_addr = dst_r + w_r;
  assign sw_addr = src_r + w_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = outv_r;
  assign out_tdata  = {7'd0, free_r, co_r, ao_r, ho_r, st_r};

  // table read addresses; data lands in u_rd_r / h_rd_r next cycle
  always_comb begin
    u_ra = uu;
    h_ra = ih;
    case (state_r)
      S_ASH_RD: u_ra = UW'(src_r - 1'b1);
      S_FS_RD:  u_ra = UW'(u_r + 1'b1);
      S_HD_RD:  h_ra = HW'(i_r + 1'b1);
      S_HI_RD:  h_ra = HW'(best_r - 1'b1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    u_rd_r <= used_mem[u_ra];
    h_rd_r <= hole_mem[h_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_cnt_r  <= '0;
      hole_cnt_r  <= CW'(1);
      free_r      <= LW'(MemWords);
      next_h_r    <= '0;
      fill_addr_r <= '0;
      fill_left_r <= '0;
      outv_r      <= 1'b0;
      hole_mem[0] <= '{start: '0, len: LW'(MemWords)};
    end else begin
      unique case (state_r)
        S_IDLE: if (in_tvalid) begin
          req_r  <= in_tuser;
          size_r <= in_tdata[10:0];
          hin_r  <= in_tdata[26:11];
          dw_r   <= WordBits'(in_tdata[58:27]);
          ho_r <= '0; ao_r <= '0; co_r <= 1'b0;
          i_r <= '0; u_r <= '0; best_v_r <= 1'b0;
          unique case (req_t'(in_tuser))
            REQ_ALLOC: begin
              fill_left_r <= '0;
              if (in_tdata[10:0] == '0) begin st_r <= ST_BAD_ITEM; state_r <= S_DONE; end
              else if (in_tdata[10:0] > free_r) begin
                st_r <= ST_NO_SPACE; state_r <= S_DONE;
              end else if (used_cnt_r >= (UW+1)'(MaxBlocks)) begin
                st_r <= ST_TBL_FULL; state_r <= S_DONE;
              end else begin st_r <= ST_OK; state_r <= S_AS_RD; end
            end
            REQ_FREE: begin
              fill_left_r <= '0; st_r <= ST_OK; state_r <= S_FF_RD;
            end
            REQ_DATA: begin
              if (fill_left_r != '0) begin st_r <= ST_OK; state_r <= S_DATA; end
              else begin st_r <= ST_BAD_ITEM; state_r <= S_DONE; end
            end
            default: begin st_r <= ST_BAD_ITEM; state_r <= S_DONE; end
          endcase
        end
        S_DATA: begin
          if (fill_addr_r < LW'(MemWords)) word_mem[fill_addr_r[AW-1:0]] <= dw_r;
          fill_addr_r <= fill_addr_r + 1'b1;
          fill_left_r <= fill_left_r - 1'b1;
          state_r <= S_DONE;
        end
        // best-fit search, one hole per step
        S_AS_RD: begin
          if (i_r == hole_cnt_r) begin
            if (best_v_r) begin i_r <= best_r; state_r <= S_AP_RD; end
            else begin u_r <= '0; dst_r <= '0; state_r <= S_CS_RD; end
          end else state_r <= S_AS_EV;
        end
        S_AS_EV: begin
          if (h_rd_r.len >= size_r && (!best_v_r || h_rd_r.len < best_len_r)) begin
            best_r <= i_r; best_v_r <= 1'b1; best_len_r <= h_rd_r.len;
            addr_r <= h_rd_r.start[AW-1:0];
            if (h_rd_r.len == size_r) state_r <= S_AP_RD;   // exact fit stops the scan
            else begin i_r <= i_r + 1'b1; state_r <= S_AS_RD; end
          end else begin
            i_r <= i_r + 1'b1; state_r <= S_AS_RD;
          end
        end
        // i_r holds the chosen hole; find insertion point in used table
        S_AP_RD: begin
          if (u_r == used_cnt_r) begin
            src_r <= LW'(used_cnt_r); state_r <= S_ASH_RD;
          end else state_r <= S_AP_EV;
        end
        S_AP_EV: begin
          if (u_rd_r.start < addr_r) begin u_r <= u_r + 1'b1; state_r <= S_AP_RD; end
          else begin src_r <= LW'(used_cnt_r); state_r <= S_ASH_RD; end
        end
        S_ASH_RD: begin  // src_r walks down from used_cnt to pos
          if (src_r > LW'(u_r)) state_r <= S_ASH_WR;
          else if (best_len_r == size_r) state_r <= S_HD_RD;
          else begin
            hole_mem[ih] <= '{start: LW'(addr_r) + size_r, len: best_len_r - size_r};
            state_r <= S_AFIN;
          end
        end
        S_ASH_WR: begin
          used_mem[src_r[UW-1:0]] <= u_rd_r;
          src_r <= src_r - 1'b1;
          state_r <= S_ASH_RD;
        end
        S_AFIN: begin
          used_mem[uu] <= '{start: addr_r, len: size_r, handle: next_h_r};
          used_cnt_r <= used_cnt_r + 1'b1;
          free_r <= free_r - size_r;
          if (free_r == size_r) hole_cnt_r <= '0;
          ho_r <= next_h_r; ao_r <= addr_r;
          next_h_r <= next_h_r + 1'b1;
          fill_addr_r <= LW'(addr_r); fill_left_r <= size_r;
          state_r <= S_DONE;
        end
        // compaction: per block, copy words low to high
        S_CS_RD: begin
          if (u_r == used_cnt_r) state_r <= S_CDONE;
          else state_r <= S_CS_EV;
        end
        S_CS_EV: begin
          src_r <= LW'(u_rd_r.start); fsz_r <= u_rd_r.len; w_r <= '0;
          used_mem[uu] <= '{start: dst_r[AW-1:0], len: u_rd_r.len, handle: u_rd_r.handle};
          state_r <= S_CRD;
        end
        S_CRD: begin
          if (w_r == fsz_r) begin
            dst_r <= dst_r + fsz_r; u_r <= u_r + 1'b1; state_r <= S_CS_RD;
          end else begin
            rd_r <= word_mem[sw_addr[AW-1:0]];
            state_r <= S_CWR;
          end
        end
        S_CWR: begin
          if (dw_addr < LW'(MemWords) && sw_addr < LW'(MemWords))
            word_mem[dw_addr[AW-1:0]] <= rd_r;
          w_r <= w_r + 1'b1;
          state_r <= S_CRD;
        end
        S_CDONE: begin
          hole_mem[0] <= '{start: dst_r + size_r, len: LW'(MemWords) - dst_r - size_r};
          hole_cnt_r <= CW'(1);
          addr_r <= dst_r[AW-1:0];
          co_r <= 1'b1;
          state_r <= S_AFIN;
        end
        // free: find handle, then shift table down
        S_FF_RD: begin
          if (u_r == used_cnt_r) begin st_r <= ST_NOT_FOUND; state_r <= S_DONE; end
          else state_r <= S_FF_EV;
        end
        S_FF_EV: begin
          if (u_rd_r.handle == hin_r) begin
            fl_r <= LW'(u_rd_r.start); fsz_r <= u_rd_r.len; state_r <= S_FS_RD;
          end else begin
            u_r <= u_r + 1'b1; state_r <= S_FF_RD;
          end
        end
        S_FS_RD: begin
          if (u_r + 1'b1 < used_cnt_r) state_r <= S_FS_WR;
          else begin
            used_cnt_r <= ucnt_m1;
            free_r <= free_r + fsz_r;
            i_r <= '0;
            state_r <= S_HS_RD;
          end
        end
        S_FS_WR: begin
          used_mem[uu] <= u_rd_r;
          u_r <= u_r + 1'b1;
          state_r <= S_FS_RD;
        end
        // first hole above the freed block; the one below is kept in hp_r
        S_HS_RD: begin
          if (i_r < hole_cnt_r) state_r <= S_HS_EV;
          else begin
            prev_r <= (i_r != '0) && (hp_r.start + hp_r.len == fl_r);
            next_r <= 1'b0;
            state_r <= S_HMERGE;
          end
        end
        S_HS_EV: begin
          if (h_rd_r.start <= fl_r) begin
            hp_r <= h_rd_r; i_r <= i_r + 1'b1; state_r <= S_HS_RD;
          end else begin
            he_r <= h_rd_r;
            prev_r <= (i_r != '0) && (hp_r.start + hp_r.len == fl_r);
            next_r <= (h_rd_r.start == fl_r + fsz_r);
            state_r <= S_HMERGE;
          end
        end
        S_HMERGE: begin
          if (prev_r && next_r) begin
            hole_mem[ihm1] <= '{start: hp_r.start, len: hp_r.len + fsz_r + he_r.len};
            state_r <= S_HD_RD;
          end else if (prev_r) begin
            hole_mem[ihm1] <= '{start: hp_r.start, len: hp_r.len + fsz_r};
            state_r <= S_DONE;
          end else if (next_r) begin
            hole_mem[ih] <= '{start: fl_r, len: he_r.len + fsz_r}; state_r <= S_DONE;
          end else if (hole_cnt_r < CW'(HoleDepth)) begin
            best_r <= hole_cnt_r; state_r <= S_HI_RD;
          end else state_r <= S_DONE;
        end
        // drop hole i_r by shifting the rest down (alloc exact fit or double merge)
        S_HD_RD: begin
          if (i_r + 1'b1 < hole_cnt_r) state_r <= S_HD_WR;
          else begin
            hole_cnt_r <= hole_cnt_r - 1'b1;
            if (req_r == REQ_ALLOC) state_r <= S_AFIN;
            else state_r <= S_DONE;
          end
        end
        S_HD_WR: begin
          hole_mem[ih] <= h_rd_r;
          i_r <= i_r + 1'b1;
          state_r <= S_HD_RD;
        end
        S_HI_RD: begin  // best_r walks down from hole_cnt to i_r
          if (best_r > i_r) state_r <= S_HI_WR;
          else begin
            hole_mem[ih] <= '{start: fl_r, len: fsz_r};
            hole_cnt_r <= hole_cnt_r + 1'b1;
            state_r <= S_DONE;
          end
        end
        S_HI_WR: begin
          hole_mem[best_r[HW-1:0]] <= h_rd_r;
          best_r <= best_r - 1'b1;
          state_r <= S_HI_RD;
        end
        S_DONE: begin outv_r <= 1'b1; state_r <= S_OUT; end
        S_OUT: if (out_tready) begin outv_r <= 1'b0; state_r <= S_IDLE; end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `include "best_fit_allocator_with_compaction_assert.svh"

  `BFA_ASSERT(a_free_bound, free_r <= LW'(MemWords), "free words above memory size")
  `BFA_ASSERT(a_used_bound, used_cnt_r <= (UW+1)'(MaxBlocks), "used count overflow")
  `BFA_ASSERT(a_valid_state, outv_r == (state_r == S_OUT), "result valid outside output state")
  `BFA_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")
endmodule
